// ===== rtl/mtc_pkg.sv =====
package mtc_pkg;

    localparam int BurstMax   = 7;
    localparam int CodeTblLen = 6;
    localparam int NumCodes   = 31;

    typedef logic [7:0] t_char;

    localparam t_char ChSpace    = 8'h20;
    localparam t_char ChDot      = 8'h2e;
    localparam t_char ChDash     = 8'h2d;
    localparam t_char ChUpperA   = 8'h41;
    localparam t_char ChUpperZ   = 8'h5a;
    localparam t_char CaseOffset = 8'h20;

    localparam logic ModeEncode = 1'b0;
    localparam logic ModeDecode = 1'b1;

    // Register byte offsets; bit 2 of the address selects the register slot.
    localparam int RegModeIdx = 0;

    // All result characters caused by one input character.
    typedef struct packed {
        t_char [BurstMax-1:0] chars;
        logic [2:0]           count;
    } t_burst;

    // Symbol j of a code sits in bits[j]; a dash is 1 and a dot is 0.
    typedef struct packed {
        t_char      letter;
        logic [2:0] len;
        logic [5:0] bits;
    } t_code_entry;

    localparam t_code_entry CodeTable [NumCodes] = '{
        '{8'h61, 3'd2, 6'b000010},
        '{8'h62, 3'd4, 6'b000001},
        '{8'h63, 3'd4, 6'b000101},
        '{8'h64, 3'd3, 6'b000001},
        '{8'h65, 3'd1, 6'b000000},
        '{8'h66, 3'd4, 6'b000100},
        '{8'h67, 3'd3, 6'b000011},
        '{8'h68, 3'd4, 6'b000000},
        '{8'h69, 3'd2, 6'b000000},
        '{8'h6a, 3'd4, 6'b001110},
        '{8'h6b, 3'd3, 6'b000101},
        '{8'h6c, 3'd4, 6'b000010},
        '{8'h6d, 3'd2, 6'b000011},
        '{8'h6e, 3'd2, 6'b000001},
        '{8'h6f, 3'd3, 6'b000111},
        '{8'h70, 3'd4, 6'b000110},
        '{8'h71, 3'd4, 6'b001011},
        '{8'h72, 3'd3, 6'b000010},
        '{8'h73, 3'd3, 6'b000000},
        '{8'h74, 3'd1, 6'b000001},
        '{8'h75, 3'd3, 6'b000100},
        '{8'h76, 3'd4, 6'b001000},
        '{8'h77, 3'd3, 6'b000110},
        '{8'h78, 3'd4, 6'b001001},
        '{8'h79, 3'd4, 6'b001101},
        '{8'h7a, 3'd4, 6'b000011},
        '{8'h2c, 3'd6, 6'b110011},
        '{8'h21, 3'd6, 6'b110101},
        '{8'h28, 3'd5, 6'b001101},
        '{8'h29, 3'd6, 6'b101101},
        '{8'h3f, 3'd6, 6'b001100}
    };

endpackage

// ===== rtl/mtc_in_if.sv =====
interface mtc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       msg_start;

    modport source (output valid, output char_in, output msg_start, input ready);
    modport sink   (input valid, input char_in, input msg_start, output ready);
endinterface

// ===== rtl/mtc_out_if.sv =====
interface mtc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

// ===== rtl/mtc_step.sv =====
module mtc_step
    import mtc_pkg::*;
#(
    parameter int MAX_CODE_LEN = 6
) (
    input  logic                             i_mode,
    input  t_char                            i_char,
    input  logic                             i_msg_start,
    input  logic                             i_skip,
    input  logic [MAX_CODE_LEN-1:0]          i_bits,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0] i_len,
    input  logic                             i_inv,
    output logic                             o_skip,
    output logic [MAX_CODE_LEN-1:0]          o_bits,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0] o_len,
    output logic                             o_inv,
    output logic                             o_has_result,
    output t_burst                           o_burst
);

    localparam int LenW = $clog2(MAX_CODE_LEN + 1);

    t_char                   c_low;
    logic                    skip0;
    logic [MAX_CODE_LEN-1:0] bits0;
    logic [LenW-1:0]         len0;
    logic                    inv0;
    logic                    hit;
    t_code_entry             entry;
    t_char                   letter;

    always_comb begin
        c_low = i_char;
        if (i_char >= ChUpperA && i_char <= ChUpperZ) begin
            c_low = i_char + CaseOffset;
        end

        skip0 = i_skip | i_msg_start;
        bits0 = i_msg_start ? '0 : i_bits;
        len0  = i_msg_start ? '0 : i_len;
        inv0  = i_msg_start ? 1'b0 : i_inv;

        o_skip       = skip0;
        o_bits       = bits0;
        o_len        = len0;
        o_inv        = inv0;
        o_has_result = 1'b0;
        o_burst      = '0;
        hit          = 1'b0;
        entry        = '0;
        letter       = ChSpace;

        if (!(skip0 && i_char == ChSpace)) begin
            o_skip = 1'b0;
            if (i_mode == ModeEncode) begin
                o_has_result = 1'b1;
                if (c_low == ChSpace) begin
                    o_burst.chars[0] = ChSpace;
                    o_burst.chars[1] = ChSpace;
                    o_burst.count    = 3'd2;
                end else begin
                    for (int k = 0; k < NumCodes; k++) begin
                        if (!hit && CodeTable[k].letter == c_low) begin
                            hit   = 1'b1;
                            entry = CodeTable[k];
                        end
                    end
                    if (hit) begin
                        for (int j = 0; j < CodeTblLen; j++) begin
                            if (3'(j) < entry.len) begin
                                o_burst.chars[j] = entry.bits[j] ? ChDash : ChDot;
                            end
                        end
                        o_burst.chars[entry.len] = ChSpace;
                        o_burst.count            = entry.len + 3'd1;
                    end else begin
                        o_burst.chars[0] = ChSpace;
                        o_burst.count    = 3'd1;
                    end
                end
            end else if (i_char != ChSpace) begin
                if (i_char != ChDot && i_char != ChDash) begin
                    o_inv = 1'b1;
                end else if (len0 >= LenW'(MAX_CODE_LEN)) begin
                    o_inv = 1'b1;
                end else begin
                    for (int k = 0; k < MAX_CODE_LEN; k++) begin
                        if (i_char == ChDash && LenW'(k) == len0) begin
                            o_bits[k] = 1'b1;
                        end
                    end
                    o_len = len0 + LenW'(1);
                end
            end else begin
                if (!inv0 && len0 != '0) begin
                    for (int k = 0; k < NumCodes; k++) begin
                        if (!hit && len0 == LenW'(CodeTable[k].len)
                                 && bits0 == MAX_CODE_LEN'(CodeTable[k].bits)) begin
                            hit    = 1'b1;
                            letter = CodeTable[k].letter;
                        end
                    end
                end
                o_burst.chars[0] = letter;
                o_burst.count    = 3'd1;
                o_has_result     = 1'b1;
                o_bits           = '0;
                o_len            = '0;
                o_inv            = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/morse_text_codec.sv =====
// Morse text codec.
// The input channel carries one ASCII character per beat together with a
// message start flag. The output channel carries one character per beat,
// with last marking the final beat caused by an input character.
// The mode register at byte address 0 of the APB-style port selects encoding
// (0) or decoding (1); the user must write it only while the block is idle,
// which the block does not enforce. An accepted character is processed in
// the cycle it is taken; its results are registered into the output stage,
// or the pending stage while a burst drains. While the receiver is ready,
// decoding gives at most one result beat per input beat, so the block
// sustains one input character per cycle; encoding gives up to seven beats
// per character, and the single output port sends one beat per cycle.
// A pending stage holds the results of the next character while the current
// burst drains, so input ready depends only on registered state.
// When the receiver stalls, the current beat holds and, once the pending
// stage is full, input ready drops.
// Reset clears the mode to encode, re-arms leading-space skipping, and
// empties the code buffer and both output stages.
module morse_text_codec
    import mtc_pkg::*;
#(
    parameter int MAX_CODE_LEN = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mtc_in_if.sink           i_in,
    mtc_out_if.source        o_out,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LenW = $clog2(MAX_CODE_LEN + 1);

    logic                    r_mode;
    logic                    r_skip;
    logic [MAX_CODE_LEN-1:0] r_bits;
    logic [LenW-1:0]         r_len;
    logic                    r_inv;
    t_burst                  r_pend;
    logic                    r_pend_v;
    t_burst                  r_act;
    logic                    r_act_v;
    logic [2:0]              r_idx;

    logic                    n_skip;
    logic [MAX_CODE_LEN-1:0] n_bits;
    logic [LenW-1:0]         n_len;
    logic                    n_inv;
    t_burst                  n_pend;
    logic                    n_pend_v;
    t_burst                  n_act;
    logic                    n_act_v;
    logic [2:0]              n_idx;

    logic                    in_fire;
    logic                    act_last;
    logic                    act_done;
    logic                    has_result;
    t_burst                  burst;
    logic                    reg_sel;

    mtc_step #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_step (
        .i_mode      (r_mode),
        .i_char      (i_in.char_in),
        .i_msg_start (i_in.msg_start),
        .i_skip      (r_skip),
        .i_bits      (r_bits),
        .i_len       (r_len),
        .i_inv       (r_inv),
        .o_skip      (n_skip),
        .o_bits      (n_bits),
        .o_len       (n_len),
        .o_inv       (n_inv),
        .o_has_result(has_result),
        .o_burst     (burst)
    );

    assign reg_sel = (paddr[2] == 1'(RegModeIdx));
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {31'b0, r_mode} : 32'b0;

    assign i_in.ready = !r_pend_v;
    assign in_fire    = i_in.valid && !r_pend_v;

    assign act_last = (r_idx == r_act.count - 3'd1);
    assign act_done = r_act_v && o_out.ready && act_last;

    assign o_out.valid    = r_act_v;
    assign o_out.char_out = r_act.chars[r_idx];
    assign o_out.last     = act_last;

    always_comb begin
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_act    = r_act;
        n_act_v  = r_act_v;
        n_idx    = r_idx;

        if (r_act_v && o_out.ready && !act_last) begin
            n_idx = r_idx + 3'd1;
        end

        if (!r_act_v || act_done) begin
            if (r_pend_v) begin
                n_act    = r_pend;
                n_act_v  = 1'b1;
                n_pend_v = 1'b0;
                n_idx    = 3'd0;
            end else if (in_fire && has_result) begin
                n_act   = burst;
                n_act_v = 1'b1;
                n_idx   = 3'd0;
            end else begin
                n_act_v = 1'b0;
            end
        end else if (in_fire && has_result) begin
            n_pend   = burst;
            n_pend_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ModeEncode;
            r_skip   <= 1'b1;
            r_bits   <= '0;
            r_len    <= '0;
            r_inv    <= 1'b0;
            r_pend_v <= 1'b0;
            r_act_v  <= 1'b0;
            r_idx    <= 3'd0;
        end else begin
            if (psel && penable && pwrite && reg_sel) begin
                r_mode <= pwdata[0];
            end
            if (in_fire) begin
                r_skip <= n_skip;
                r_bits <= n_bits;
                r_len  <= n_len;
                r_inv  <= n_inv;
            end
            r_pend_v <= n_pend_v;
            r_act_v  <= n_act_v;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_act  <= n_act;
    end

endmodule

// ===== rtl/mtc_checker.sv =====
module mtc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last,
    input logic       i_psel,
    input logic       i_penable,
    input logic       i_pwrite,
    input logic [2:0] i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] i_prdata
);

    // A stalled beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("output beat changed while stalled");

    // A burst runs without gaps until its last beat.
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside a result burst");

    // Input back-pressure only appears while results are waiting.
    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

    // A write to the mode register reads back on the next cycle.
    a_mode_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && !i_paddr[2] |=>
            i_paddr[2] || i_prdata[0] == $past(i_pwdata[0]))
        else $error("mode register readback mismatch");

    // Reset empties the output stage.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind morse_text_codec mtc_checker u_mtc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_char (o_out.char_out),
    .i_out_last (o_out.last),
    .i_psel     (psel),
    .i_penable  (penable),
    .i_pwrite   (pwrite),
    .i_paddr    (paddr),
    .i_pwdata   (pwdata),
    .i_prdata   (prdata)
);
